// ===== src/pmt_pkg.sv =====
// Types and constants shared by the pending message table modules.
package pmt_pkg;

  // Operation codes carried in the kind field
  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_POP    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_LOOKUP = 3'd3;
  localparam logic [2:0] KIND_QUERY  = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  // One operation request
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] unique_id;
    logic [7:0]         action_code;
    logic [15:0]        payload_handle;
  } in_t;

  // One operation result
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [7:0]  found_action;
    logic [15:0] found_payload;
    logic [4:0]  entry_count;
  } out_t;

  // One stored table entry
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  action;
    logic [15:0] payload;
  } entry_t;

  // Oldest-match token passed down the cell chain
  typedef struct packed {
    logic        hit;
    logic [7:0]  action;
    logic [15:0] payload;
  } carry_t;

  // What each cell compares against during a scan
  typedef enum logic [1:0] {
    MATCH_NONE,
    MATCH_HEAD,
    MATCH_ID,
    MATCH_ACT
  } match_e;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    match_e      mode;
    logic [31:0] key_id;
    logic [7:0]  key_action;
    entry_t      new_entry;
    logic        scan_clear;
    logic        scan_en;
    logic        remove_en;
    logic        append_en;
  } cell_ctrl_t;

endpackage

// ===== src/pending_message_table_top.sv =====
// Pending message table: ordered entry store built as a chain of cells.
//
//  Channel | Signals                           | Moves
//  --------+-----------------------------------+-------------------------------
//  input   | in_valid_i, in_ready_o, in_data_i | one operation request per transfer
//  output  | out_valid_o, out_ready_i, out_data_o | one result per transfer
//
// Every operation is accepted in S_IDLE, scanned in S_SCAN while the oldest-match
// token ripples one cell per cycle down the chain, and committed in S_DONE.
// A waiting result sits in the output register; the next request is accepted
// meanwhile and its commit holds until the output register is free.
// Reset empties the table at once; stored entries are not cleared.
module pending_message_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pmt_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pmt_pkg::out_t  out_data_o
);

  localparam int unsigned CntW  = $clog2(ENTRIES + 1);
  localparam int unsigned StepW = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [StepW-1:0]   step_q;
  pmt_pkg::in_t       req_q;
  logic [CntW-1:0]    count_q, count_d;
  pmt_pkg::out_t      out_q, res_d;
  logic               out_valid_q;

  logic               in_xfer;
  logic               commit;
  logic               is_full;
  logic               is_empty;
  pmt_pkg::cell_ctrl_t ctrl;
  pmt_pkg::carry_t    fin;

  pmt_pkg::entry_t    entry_w [ENTRIES];
  pmt_pkg::carry_t    carry_w [ENTRIES+1];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign commit     = (state_q == S_DONE) & (~out_valid_q | out_ready_i);
  assign is_full    = (count_q >= CntW'(ENTRIES));
  assign is_empty   = (count_q == '0);
  assign fin        = carry_w[ENTRIES];

  // Broadcast control to the cells
  always_comb begin
    ctrl = '0;
    case (req_q.kind)
      pmt_pkg::KIND_POP:    ctrl.mode = pmt_pkg::MATCH_HEAD;
      pmt_pkg::KIND_REMOVE: ctrl.mode = pmt_pkg::MATCH_ID;
      pmt_pkg::KIND_LOOKUP: ctrl.mode = pmt_pkg::MATCH_ID;
      pmt_pkg::KIND_QUERY:  ctrl.mode = pmt_pkg::MATCH_ACT;
      default:              ctrl.mode = pmt_pkg::MATCH_NONE;
    endcase
    ctrl.key_id            = req_q.unique_id;
    ctrl.key_action        = req_q.action_code;
    ctrl.new_entry.id      = req_q.unique_id;
    ctrl.new_entry.action  = req_q.action_code;
    ctrl.new_entry.payload = req_q.payload_handle;
    ctrl.scan_clear        = in_xfer;
    ctrl.scan_en           = (state_q == S_SCAN);
    ctrl.remove_en         = commit & fin.hit &
                             ((req_q.kind == pmt_pkg::KIND_REMOVE) ||
                              (req_q.kind == pmt_pkg::KIND_POP));
    ctrl.append_en         = commit & ~is_full & (req_q.kind == pmt_pkg::KIND_APPEND);
  end

  // Cell chain; the token enters cell 0 empty
  assign carry_w[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pmt_pkg::entry_t nbr;
    if (i == ENTRIES - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entry_w[i+1];
    end

    pmt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .head_i     (1'(i == 0)),
      .occupied_i (CntW'(i) < count_q),
      .tail_i     (CntW'(i) == count_q),
      .nbr_i      (nbr),
      .carry_i    (carry_w[i]),
      .entry_o    (entry_w[i]),
      .carry_o    (carry_w[i+1])
    );
  end

  // Result and new count at commit
  always_comb begin
    res_d   = '0;
    count_d = count_q;
    case (req_q.kind)
      pmt_pkg::KIND_APPEND: begin
        if (is_full) begin
          res_d.status = pmt_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      pmt_pkg::KIND_POP: begin
        if (is_empty) begin
          res_d.status = pmt_pkg::STATUS_EMPTY;
        end else begin
          res_d.found_payload = fin.payload;
          count_d             = count_q - CntW'(1);
        end
      end
      pmt_pkg::KIND_REMOVE, pmt_pkg::KIND_LOOKUP: begin
        if (is_empty) begin
          res_d.status = pmt_pkg::STATUS_EMPTY;
        end else if (!fin.hit) begin
          res_d.status = pmt_pkg::STATUS_NOTFOUND;
        end else begin
          res_d.found         = 1'b1;
          res_d.found_payload = fin.payload;
          if (req_q.kind == pmt_pkg::KIND_LOOKUP) begin
            res_d.found_action = fin.action;
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      pmt_pkg::KIND_QUERY: begin
        if (is_empty) begin
          res_d.status = pmt_pkg::STATUS_EMPTY;
        end else begin
          res_d.found = fin.hit;
        end
      end
      default: ;
    endcase
    res_d.entry_count = 5'(count_d);
  end

  // Sequencer, occupancy and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      out_q       <= '0;
    end else begin
      // a commit in the same cycle refills the output register itself
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            req_q   <= in_data_i;
            step_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step_q == StepW'(ENTRIES - 1)) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        S_DONE: begin
          if (commit) begin
            out_q       <= res_d;
            out_valid_q <= 1'b1;
            count_q     <= count_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupancy never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("occupancy above table depth");

  // Occupancy moves only at a commit
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> count_q == $past(count_q))
    else $error("occupancy changed outside commit");

  // An accepted request always starts a scan
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == S_SCAN)
    else $error("accepted request did not start a scan");

  // A match is only reported with ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.found) |-> out_q.status == pmt_pkg::STATUS_OK)
    else $error("found flag with error status");

endmodule

// ===== src/pmt_cell.sv =====
// One table slot: holds an entry, matches it, and forwards the oldest-match token.
module pmt_cell (
  input  logic                clk_i,
  input  pmt_pkg::cell_ctrl_t ctrl_i,
  input  logic                head_i,
  input  logic                occupied_i,
  input  logic                tail_i,
  input  pmt_pkg::entry_t     nbr_i,
  input  pmt_pkg::carry_t     carry_i,
  output pmt_pkg::entry_t     entry_o,
  output pmt_pkg::carry_t     carry_o
);

  pmt_pkg::entry_t entry_q, entry_d;
  pmt_pkg::carry_t carry_q, carry_d;
  logic            match;

  // Compare the held entry against the broadcast key
  always_comb begin
    case (ctrl_i.mode)
      pmt_pkg::MATCH_HEAD: match = occupied_i & head_i;
      pmt_pkg::MATCH_ID:   match = occupied_i & (entry_q.id == ctrl_i.key_id);
      pmt_pkg::MATCH_ACT:  match = occupied_i & (entry_q.action == ctrl_i.key_action);
      default:             match = 1'b0;
    endcase
  end

  // Token: an earlier hit passes through, otherwise this cell may claim it
  always_comb begin
    carry_d = carry_q;
    if (ctrl_i.scan_clear) begin
      carry_d = '0;
    end else if (ctrl_i.scan_en) begin
      if (carry_i.hit) begin
        carry_d = carry_i;
      end else begin
        carry_d.hit     = match;
        carry_d.action  = entry_q.action;
        carry_d.payload = entry_q.payload;
      end
    end
  end

  // Entry update: close the gap left by a removal, or take a new tail entry
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.remove_en && (carry_i.hit || match)) begin
      entry_d = nbr_i;
    end else if (ctrl_i.append_en && tail_i) begin
      entry_d = ctrl_i.new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    carry_q <= carry_d;
  end

  assign entry_o = entry_q;
  assign carry_o = carry_q;

endmodule
